>>> design/pwows_pkg.sv
// shared types and constants of the pulse-width one-wire sender
// no dependencies; imported by every module of the block
package pwows_pkg;

    // number of data bits sent per word, least significant first
    localparam int DATA_BITS = 8;

    localparam int TICK_W    = 10;
    localparam int BYTE_W    = 8;
    localparam int BITS_W    = $clog2(DATA_BITS + 1);
    localparam int CFG_IDX_W = 2;

    // register reset values, for a 100 us tick
    localparam logic [TICK_W-1:0] LONG_TICKS_RST  = TICK_W'(12);
    localparam logic [TICK_W-1:0] SHORT_TICKS_RST = TICK_W'(4);
    localparam logic [TICK_W-1:0] SYNC_TICKS_RST  = TICK_W'(30);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_TICKS  = 2'd0,
        REG_SHORT_TICKS = 2'd1,
        REG_SYNC_TICKS  = 2'd2
    } cfg_idx_t;

    // input commands
    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HDR_HIGH = 3'd1,
        PH_SYNC_LOW = 3'd2,
        PH_BIT_HIGH = 3'd3,
        PH_BIT_LOW  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [TICK_W-1:0] long_ticks;
        logic [TICK_W-1:0] short_ticks;
        logic [TICK_W-1:0] sync_low_ticks;
    } cfg_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic start_refused;
    } res_t;

endpackage

>>> design/pwows_cfg_regs.sv
// timing configuration registers of the pulse-width one-wire sender
// depends on pwows_pkg
module pwows_cfg_regs
    import pwows_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_LONG_TICKS:  cfg_next.long_ticks     = cfg_data;
                REG_SHORT_TICKS: cfg_next.short_ticks    = cfg_data;
                REG_SYNC_TICKS:  cfg_next.sync_low_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_ticks     <= LONG_TICKS_RST;
            cfg_reg.short_ticks    <= SHORT_TICKS_RST;
            cfg_reg.sync_low_ticks <= SYNC_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> design/pwows_core.sv
// phase sequencer of the pulse-width one-wire sender: state and one-word step
// depends on pwows_pkg
module pwows_core
    import pwows_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic              command,
    input  logic [BYTE_W-1:0] data_byte,
    input  cfg_t              cfg,
    output res_t              res
);

    phase_t             phase_reg,     phase_next;
    logic [TICK_W-1:0]  time_left_reg, time_left_next;
    logic [BYTE_W-1:0]  shift_reg,     shift_next;
    logic [BITS_W-1:0]  bits_left_reg, bits_left_next;
    logic               line_reg,      line_next;

    logic               busy;
    logic               refused;
    logic [BITS_W-1:0]  bits_dec;

    always_comb
    begin
        busy = (phase_reg == PH_HDR_HIGH) || (phase_reg == PH_SYNC_LOW) ||
               (phase_reg == PH_BIT_HIGH) || (phase_reg == PH_BIT_LOW);

        phase_next     = phase_reg;
        time_left_next = time_left_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        line_next      = line_reg;
        refused        = 1'b0;
        bits_dec       = bits_left_reg;

        if (!busy)
        begin
            phase_next = PH_IDLE;
            line_next  = 1'b1;
        end

        if (cmd_t'(command) == CMD_START)
        begin
            if (busy)
            begin
                refused = 1'b1;
            end
            else
            begin
                phase_next     = PH_HDR_HIGH;
                line_next      = 1'b1;
                time_left_next = cfg.long_ticks;
                shift_next     = data_byte;
                bits_left_next = BITS_W'(DATA_BITS);
            end
        end
        else if (busy)
        begin
            if (time_left_reg > TICK_W'(1))
            begin
                time_left_next = time_left_reg - TICK_W'(1);
            end
            else
            begin
                unique case (phase_reg)
                    PH_HDR_HIGH:
                    begin
                        phase_next     = PH_SYNC_LOW;
                        line_next      = 1'b0;
                        time_left_next = cfg.sync_low_ticks;
                    end
                    PH_SYNC_LOW:
                    begin
                        if (bits_left_reg != '0)
                        begin
                            phase_next     = PH_BIT_HIGH;
                            line_next      = 1'b1;
                            time_left_next = shift_reg[0] ? cfg.long_ticks : cfg.short_ticks;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            line_next      = 1'b1;
                            time_left_next = '0;
                        end
                    end
                    PH_BIT_HIGH:
                    begin
                        phase_next     = PH_BIT_LOW;
                        line_next      = 1'b0;
                        time_left_next = shift_reg[0] ? cfg.short_ticks : cfg.long_ticks;
                    end
                    PH_BIT_LOW:
                    begin
                        shift_next = shift_reg >> 1;
                        if (bits_left_reg != '0)
                        begin
                            bits_dec = bits_left_reg - BITS_W'(1);
                        end
                        bits_left_next = bits_dec;
                        if (bits_dec != '0)
                        begin
                            phase_next     = PH_BIT_HIGH;
                            line_next      = 1'b1;
                            time_left_next = shift_next[0] ? cfg.long_ticks : cfg.short_ticks;
                        end
                        else
                        begin
                            phase_next     = PH_IDLE;
                            line_next      = 1'b1;
                            time_left_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next     = PH_IDLE;
                        line_next      = 1'b1;
                        time_left_next = '0;
                    end
                endcase
            end
        end

        res.line_level    = line_next;
        res.busy_res      = (phase_next == PH_HDR_HIGH) || (phase_next == PH_SYNC_LOW) ||
                            (phase_next == PH_BIT_HIGH) || (phase_next == PH_BIT_LOW);
        res.start_refused = refused;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            time_left_reg <= '0;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            line_reg      <= 1'b1;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            time_left_reg <= time_left_next;
            shift_reg     <= shift_next;
            bits_left_reg <= bits_left_next;
            line_reg      <= line_next;
        end
    end

endmodule

>>> design/pulse_width_one_wire_sender_unit.sv
// top level of the pulse-width one-wire sender: input register, result register, handshake
// depends on pwows_pkg, pwows_cfg_regs and pwows_core
//
// Each word in is either a tick (command 0) or a start (command 1, with data_byte). A start
// taken while idle sends the byte as a pulse-width coded frame: header high for long_ticks,
// sync low for sync_low_ticks, then DATA_BITS bits lsb first, a one as long high and short
// low, a zero as short high and long low; the line idles high. A start while busy is refused
// and flagged without touching the state. Every word gives exactly one result word holding
// the line level, the busy flag and the refused flag after that word. One word is taken per
// clock unless item_stall holds it off; a word sits in the input register, then the result
// register, the sequencer state updated between them. A waiting result does not block the
// input register from filling. No clearing pass follows reset. Registers take effect from the
// next phase load and are to be written by the user only while no word is in flight, unchecked.
module pulse_width_one_wire_sender_unit
    import pwows_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TICK_W-1:0]    cfg_data,
    // input words
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic                 command,
    input  logic [BYTE_W-1:0]    data_byte,
    // result words
    output logic                 res_valid,
    input  logic                 res_stall,
    output logic                 line_level,
    output logic                 busy_res,
    output logic                 start_refused
);

    cfg_t              cfg;
    res_t              step_res;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic              cmd_reg;
    logic [BYTE_W-1:0] data_reg;

    // result register
    logic              res_valid_reg, res_valid_next;
    res_t              res_reg;

    logic              item_take;
    logic              out_free;
    logic              advance;

    // result slot is free when empty or being emptied this cycle
    assign out_free   = !res_valid_reg || !res_stall;
    assign advance    = in_valid_reg && out_free;
    assign item_stall = in_valid_reg && !out_free;
    assign item_take  = item_valid && !item_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (out_free)
        begin
            res_valid_next = advance;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            cmd_reg  <= command;
            data_reg <= data_byte;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    pwows_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer steps once per word moving into the result register
    pwows_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .command   (cmd_reg),
        .data_byte (data_reg),
        .cfg       (cfg),
        .res       (step_res)
    );

    assign res_valid     = res_valid_reg;
    assign line_level    = res_reg.line_level;
    assign busy_res      = res_reg.busy_res;
    assign start_refused = res_reg.start_refused;

`ifndef SYNTHESIS
    // a refused start leaves the sender busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && start_refused) |-> busy_res)
        else $error("refused start reported while idle");

    // an idle sender holds the line high
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !busy_res) |-> line_level)
        else $error("line low while idle");

    // input is only held off when the input register is full
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> in_valid_reg)
        else $error("input stalled with empty input register");

    // a new result only appears after a word was waiting in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(in_valid_reg))
        else $error("result appeared without a word in flight");
`endif

endmodule

>>> sim/tb_pulse_width_one_wire_sender_unit.sv
// testbench of pulse_width_one_wire_sender_unit: a directed table of words, then random words,
// each result word checked field by field against the table or a copy of the frame sequencer
// depends on pwows_pkg and the rtl of the block
module tb_pulse_width_one_wire_sender_unit;
    import pwows_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 6;
    // margin for the input and result registers of the block to drain
    localparam int SETTLE_CYCLES   = 6;
    // long receiver hold-off, well past the two words the block can buffer
    localparam int HOLD_OFF_CYCLES = 60;
    // cycles with nothing taken on either side before the run is declared hung
    localparam int WATCHDOG_LIMIT  = 2000;
    // printing stops after this many mismatch lines, counting does not
    localparam int REPORT_LINES    = 100;
    localparam int DIRECTED_ROWS   = 21;

    // index with no register behind it, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // one row of the directed table; want is only used where typed is set
    typedef struct {
        cmd_t              cmd;
        logic [BYTE_W-1:0] payload;
        bit                typed;
        res_t              want;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_data;
    logic                 item_valid;
    logic                 item_stall;
    logic                 command;
    logic [BYTE_W-1:0]    data_byte;
    logic                 res_valid;
    logic                 res_stall;
    logic                 line_level;
    logic                 busy_res;
    logic                 start_refused;

    // local copy of the register file
    logic [TICK_W-1:0]    long_set;
    logic [TICK_W-1:0]    short_set;
    logic [TICK_W-1:0]    sync_set;

    // local copy of the frame sequencer
    phase_t               seq_phase;
    logic [TICK_W-1:0]    ticks_left;
    logic [BYTE_W-1:0]    bits_pending;
    logic [BITS_W-1:0]    bits_to_go;
    logic                 line_now;

    // line, busy and refused flags still owed by the block, oldest first
    res_t                 line_states_q [$];

    int unsigned          mismatch_count = 0;
    bit                   hold_off_req   = 1'b0;
    int unsigned          steady_words   = 0;

    // directed words, starting from reset values (long 12 ticks):
    // a tick while idle, a start of all ones, a start refused in the header,
    // the header held high for eleven ticks and dropping on the twelfth,
    // a start refused during sync low, then a few ticks into sync
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b0, 1'b0}},
        '{CMD_START, 8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_START, 8'h00, 1'b1, '{1'b1, 1'b1, 1'b1}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b1, 1'b1, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b1, '{1'b0, 1'b1, 1'b0}},
        '{CMD_START, 8'h5A, 1'b1, '{1'b0, 1'b1, 1'b1}},
        '{CMD_TICK,  8'hA5, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{CMD_TICK,  8'hFF, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{CMD_TICK,  8'h00, 1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    pulse_width_one_wire_sender_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .command       (command),
        .data_byte     (data_byte),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .line_level    (line_level),
        .busy_res      (busy_res),
        .start_refused (start_refused)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ---------------------------------------------------------------------
    // frame sequencer model
    // ---------------------------------------------------------------------

    function automatic bit frame_running();
        return seq_phase inside {PH_HDR_HIGH, PH_SYNC_LOW, PH_BIT_HIGH, PH_BIT_LOW};
    endfunction

    function automatic void end_frame();
        seq_phase  = PH_IDLE;
        line_now   = 1'b1;
        ticks_left = '0;
    endfunction

    // high part of the next bit: a one is long high, a zero short high
    function automatic void load_bit();
        seq_phase  = PH_BIT_HIGH;
        line_now   = 1'b1;
        ticks_left = bits_pending[0] ? long_set : short_set;
    endfunction

    // applies one word to the sequencer copy and returns the flags the block owes for it
    function automatic res_t step_line(cmd_t cmd, logic [BYTE_W-1:0] payload);
        res_t r;
        r.start_refused = 1'b0;
        if (!frame_running())
            end_frame();
        if (cmd == CMD_START)
        begin
            // a start in the middle of a frame is flagged and otherwise dropped
            if (frame_running())
                r.start_refused = 1'b1;
            else
            begin
                seq_phase    = PH_HDR_HIGH;
                line_now     = 1'b1;
                ticks_left   = long_set;
                bits_pending = payload;
                bits_to_go   = BITS_W'(DATA_BITS);
            end
        end
        else if (frame_running())
        begin
            // a count of zero behaves as one tick, the phase ends on the same tick
            if (ticks_left > 1)
                ticks_left = ticks_left - 1'b1;
            else
            begin
                case (seq_phase)
                    PH_HDR_HIGH:
                    begin
                        seq_phase  = PH_SYNC_LOW;
                        line_now   = 1'b0;
                        ticks_left = sync_set;
                    end
                    PH_SYNC_LOW:
                    begin
                        if (bits_to_go != 0)
                            load_bit();
                        else
                            end_frame();
                    end
                    PH_BIT_HIGH:
                    begin
                        seq_phase  = PH_BIT_LOW;
                        line_now   = 1'b0;
                        ticks_left = bits_pending[0] ? short_set : long_set;
                    end
                    PH_BIT_LOW:
                    begin
                        bits_pending = bits_pending >> 1;
                        if (bits_to_go != 0)
                            bits_to_go = bits_to_go - 1'b1;
                        if (bits_to_go != 0)
                            load_bit();
                        else
                            end_frame();
                    end
                    default:
                        end_frame();
                endcase
            end
        end
        r.line_level = line_now;
        r.busy_res   = frame_running();
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------

    // idle length for either side: mostly none or short, now and then long
    function automatic int unsigned pick_pause();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("mismatch at %0t: %s", $realtime, what);
    endtask

    // called and returns at a falling edge; valid stays high on return so that
    // back to back words need no second assignment in one step
    task automatic send_word(input cmd_t cmd, input logic [BYTE_W-1:0] payload,
                             input bit typed, input res_t want);
        int unsigned gap;
        res_t        predicted;
        if (steady_words > 0)
        begin
            steady_words--;
            gap = 0;
        end
        else
        begin
            gap = pick_pause();
            // occasional run of words with no gaps at all
            if ($urandom_range(0, 199) == 0)
                steady_words = $urandom_range(40, 120);
        end
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        command    <= cmd;
        data_byte  <= payload;
        do
            @(posedge clk);
        while (item_stall);
        predicted = step_line(cmd, payload);
        line_states_q.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    // mostly well-formed frames: starts from idle followed by ticks, with a
    // sprinkling of idle ticks and of starts that land mid-frame
    task automatic send_random(input int unsigned count);
        cmd_t cmd;
        res_t unused_want;
        unused_want = '0;
        repeat (count)
        begin
            if (frame_running())
                cmd = ($urandom_range(0, 99) < 6) ? CMD_START : CMD_TICK;
            else
                cmd = ($urandom_range(0, 99) < 75) ? CMD_START : CMD_TICK;
            send_word(cmd, BYTE_W'($urandom_range(0, 255)), 1'b0, unused_want);
        end
    endtask

    // ticks until the phase running now hands over to the next one or the frame ends
    task automatic run_out_phase();
        phase_t start_phase;
        res_t   unused_want;
        start_phase = seq_phase;
        unused_want = '0;
        while (frame_running() && (seq_phase == start_phase))
            send_word(CMD_TICK, BYTE_W'($urandom_range(0, 255)), 1'b0, unused_want);
    endtask

    // stop offering words and wait for every owed result, then let the block go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (line_states_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        case (idx)
            REG_LONG_TICKS:  long_set  = value;
            REG_SHORT_TICKS: short_set = value;
            REG_SYNC_TICKS:  sync_set  = value;
            default: ;
        endcase
    endtask

    // writes are back to back, write enable drops once after the last one;
    // a frame may still be running, its current phase keeps the old count
    task automatic apply_settings(input logic [TICK_W-1:0] long_v,
                                  input logic [TICK_W-1:0] short_v,
                                  input logic [TICK_W-1:0] sync_v,
                                  input bit poke_unused);
        write_reg(REG_LONG_TICKS, long_v);
        write_reg(REG_SHORT_TICKS, short_v);
        write_reg(REG_SYNC_TICKS, sync_v);
        if (poke_unused)
            write_reg(REG_UNUSED, TICK_W'($urandom_range(0, 1023)));
        cfg_we <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------

    initial
    begin : stimulus
        int unsigned round;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_LONG_TICKS;
        cfg_data   = '0;
        item_valid = 1'b0;
        command    = CMD_TICK;
        data_byte  = '0;

        long_set     = LONG_TICKS_RST;
        short_set    = SHORT_TICKS_RST;
        sync_set     = SYNC_TICKS_RST;
        seq_phase    = PH_IDLE;
        ticks_left   = '0;
        bits_pending = '0;
        bits_to_go   = '0;
        line_now     = 1'b1;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table at reset values
        foreach (directed_rows[i])
            send_word(directed_rows[i].cmd, directed_rows[i].payload,
                      directed_rows[i].typed, directed_rows[i].want);
        // carry on at reset values, long sync and full-length bits
        send_random(150);

        // short frames; partway through the receiver holds off while words keep coming,
        // then the sender waits for the block to empty before going on
        settle();
        apply_settings(TICK_W'(2), TICK_W'(1), TICK_W'(1), 1'b0);
        send_random(120);
        hold_off_req = 1'b1;
        send_random(10);
        settle();
        send_random(120);

        // all counts zero, every phase lasts a single tick; unused index written too
        settle();
        apply_settings('0, '0, '0, 1'b1);
        send_random(100);

        // largest counts; the phase loaded here is counted out in full below
        settle();
        apply_settings('1, '1, '1, 1'b1);
        send_random(60);

        // a few small random settings; the first one starts by ticking out the long
        // phase above, after which every phase loads the small counts
        for (round = 0; round < 3; round++)
        begin
            settle();
            apply_settings(TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
                           TICK_W'($urandom_range(1, 6)), 1'b0);
            if (round == 0)
                run_out_phase();
            send_random(70);
        end

        settle();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ---------------------------------------------------------------------
    // result side
    // ---------------------------------------------------------------------

    // receiver stall: alternating stall and flow stretches, plus one long hold-off on request
    initial
    begin : result_sink
        bit          stalling;
        int unsigned left;
        stalling  = 1'b0;
        left      = 0;
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                res_stall    <= 1'b0;
                hold_off_req  = 1'b0;
                stalling      = 1'b0;
                left          = $urandom_range(5, 20);
            end
            else if (left > 0)
                left--;
            else
            begin
                stalling = !stalling;
                if (stalling)
                    left = pick_pause();
                else if ($urandom_range(0, 19) == 0)
                    left = $urandom_range(60, 150);
                else
                    left = $urandom_range(1, 8);
                res_stall <= stalling;
            end
        end
    end

    // compare each result word taken with the oldest one owed
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (line_states_q.size() == 0)
                report_mismatch($sformatf("result word with none owed (line %b busy %b refused %b)",
                                          line_level, busy_res, start_refused));
            else
            begin
                want = line_states_q.pop_front();
                if (line_level !== want.line_level)
                    report_mismatch($sformatf("line_level got %b want %b",
                                              line_level, want.line_level));
                if (busy_res !== want.busy_res)
                    report_mismatch($sformatf("busy_res got %b want %b",
                                              busy_res, want.busy_res));
                if (start_refused !== want.start_refused)
                    report_mismatch($sformatf("start_refused got %b want %b",
                                              start_refused, want.start_refused));
            end
        end
    end

    // hang detection: counts cycles in which neither side takes a word
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> filelist.f
design/pwows_pkg.sv
design/pwows_cfg_regs.sv
design/pwows_core.sv
design/pulse_width_one_wire_sender_unit.sv
sim/tb_pulse_width_one_wire_sender_unit.sv
